// File: src/rpc_pkg.sv
// Package for the pulse colour classifier: field widths, item structs,
// colour and register codes, and the work record passed from front to back.
// No dependencies.
package rpc_pkg;

	localparam int WidthBits = 17;
	localparam int LevelBits = 8;
	localparam int MarginBits = 8;
	localparam int RemBits = WidthBits + LevelBits;
	localparam int QueueDepth = 4;
	localparam int QueuePtrBits = $clog2(QueueDepth);

	localparam logic [LevelBits-1:0] LevelFull = 8'd255;
	localparam logic [LevelBits-1:0] BlackLimit = 8'd50;
	localparam logic [LevelBits-1:0] WhiteMaxLimit = 8'd140;
	localparam logic [LevelBits-1:0] WhiteMinLimit = 8'd90;
	localparam logic [LevelBits-1:0] WhiteSpread = 8'd90;

	typedef enum logic [2:0] {
		ColorUnknown  = 3'd0,
		ColorNoObject = 3'd1,
		ColorBlack    = 3'd2,
		ColorWhite    = 3'd3,
		ColorRed      = 3'd4,
		ColorGreen    = 3'd5,
		ColorBlue     = 3'd6
	} rpc_color_t;

	typedef enum logic [2:0] {
		RegRedLow    = 3'd0,
		RegRedHigh   = 3'd1,
		RegGreenLow  = 3'd2,
		RegGreenHigh = 3'd3,
		RegBlueLow   = 3'd4,
		RegBlueHigh  = 3'd5,
		RegNoObject  = 3'd6,
		RegMargin    = 3'd7
	} rpc_reg_t;

	typedef struct packed {
		logic [WidthBits-1:0] red_width;
		logic [WidthBits-1:0] green_width;
		logic [WidthBits-1:0] blue_width;
		logic [WidthBits-1:0] clear_width;
	} rpc_in_t;

	typedef struct packed {
		logic [LevelBits-1:0] red_level;
		logic [LevelBits-1:0] green_level;
		logic [LevelBits-1:0] blue_level;
		rpc_color_t           color_code;
	} rpc_out_t;

	typedef struct packed {
		logic                 empty;
		logic [RemBits-1:0]   rem;
		logic [WidthBits-1:0] div;
		logic [LevelBits-1:0] quo;
	} rpc_chan_t;

	typedef struct packed {
		rpc_chan_t  red;
		rpc_chan_t  green;
		rpc_chan_t  blue;
		logic       fixed;
		rpc_color_t code;
	} rpc_work_t;

endpackage

// File: src/rgb_pulse_color_classifier.sv
// Pulse-width colour classifier, top level: front, queue and back.
// A result passes from the front register, which loads at its accepting edge, through the queue,
// the eight divider stages and the output register.
// Throughput is one item per cycle while the output does not stall.
// The queue holds four items, so the input keeps flowing briefly while the output stalls.
// Reset clears all valid flags and queue pointers and loads the default windows.
module rgb_pulse_color_classifier import rpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rpc_in_t              in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rpc_out_t             out_item,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [WidthBits-1:0] cfg_data
);

	logic      push, pop, queue_full, queue_empty;
	rpc_work_t push_data, head;

	rpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	rpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.head      (head)
	);

	rpc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

// File: src/rpc_front.sv
// Front part: holds the configuration registers, accepts input items, clamps
// each width to its window, forms the divider operands and classifies on the
// raw widths. Depends on rpc_pkg.
module rpc_front import rpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rpc_in_t              in_item,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [WidthBits-1:0] cfg_data,
	output logic                 push,
	output rpc_work_t            push_data,
	input  logic                 queue_full
);

	logic [WidthBits-1:0]  red_lo_q, red_hi_q, green_lo_q, green_hi_q;
	logic [WidthBits-1:0]  blue_lo_q, blue_hi_q, no_obj_q;
	logic [MarginBits-1:0] margin_q;
	logic                  valid_s1;
	rpc_work_t             work_s1;
	rpc_work_t             work_d;
	logic                  load;
	logic [WidthBits:0]    r_sum, g_sum, b_sum;
	logic [WidthBits:0]    r_ext, g_ext, b_ext;

	function automatic rpc_chan_t prep(input logic [WidthBits-1:0] x,
			input logic [WidthBits-1:0] lo, input logic [WidthBits-1:0] hi);
		rpc_chan_t            c;
		logic [WidthBits-1:0] xc;
		logic [WidthBits-1:0] diff;
		c.empty = (hi <= lo);
		if (x < lo) begin
			xc = lo;
		end else if (x > hi) begin
			xc = hi;
		end else begin
			xc = x;
		end
		diff = xc - lo;
		c.rem = c.empty ? '0 : ({diff, {LevelBits{1'b0}}} - {{LevelBits{1'b0}}, diff});
		c.div = hi - lo;
		c.quo = '0;
		return c;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_lo_q   <= WidthBits'(55);
			red_hi_q   <= WidthBits'(90);
			green_lo_q <= WidthBits'(100);
			green_hi_q <= WidthBits'(180);
			blue_lo_q  <= WidthBits'(100);
			blue_hi_q  <= WidthBits'(180);
			no_obj_q   <= WidthBits'(120);
			margin_q   <= MarginBits'(8);
		end else if (cfg_we) begin
			case (rpc_reg_t'(cfg_index))
				RegRedLow:    red_lo_q   <= cfg_data;
				RegRedHigh:   red_hi_q   <= cfg_data;
				RegGreenLow:  green_lo_q <= cfg_data;
				RegGreenHigh: green_hi_q <= cfg_data;
				RegBlueLow:   blue_lo_q  <= cfg_data;
				RegBlueHigh:  blue_hi_q  <= cfg_data;
				RegNoObject:  no_obj_q   <= cfg_data;
				RegMargin:    margin_q   <= cfg_data[MarginBits-1:0];
				default:      ;
			endcase
		end
	end

	assign r_ext = {1'b0, in_item.red_width};
	assign g_ext = {1'b0, in_item.green_width};
	assign b_ext = {1'b0, in_item.blue_width};
	assign r_sum = r_ext + (WidthBits+1)'(margin_q);
	assign g_sum = g_ext + (WidthBits+1)'(margin_q);
	assign b_sum = b_ext + (WidthBits+1)'(margin_q);

	always_comb begin
		work_d.red   = prep(in_item.red_width, red_lo_q, red_hi_q);
		work_d.green = prep(in_item.green_width, green_lo_q, green_hi_q);
		work_d.blue  = prep(in_item.blue_width, blue_lo_q, blue_hi_q);
		work_d.fixed = 1'b1;
		work_d.code  = ColorUnknown;
		if (in_item.red_width == '0 || in_item.green_width == '0 ||
				in_item.blue_width == '0 || in_item.clear_width == '0) begin
			work_d.code = ColorUnknown;
		end else if (in_item.clear_width > no_obj_q) begin
			work_d.code = ColorNoObject;
		end else begin
			work_d.fixed = 1'b0;
			if (r_sum < g_ext && r_sum < b_ext) begin
				work_d.code = ColorRed;
			end else if (g_sum < r_ext && g_sum < b_ext) begin
				work_d.code = ColorGreen;
			end else if (b_sum < r_ext && b_sum < g_ext) begin
				work_d.code = ColorBlue;
			end else begin
				work_d.code = ColorUnknown;
			end
		end
	end

	assign load     = !valid_s1 || !queue_full;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			work_s1 <= work_d;
		end
	end

	assign push      = valid_s1 && !queue_full;
	assign push_data = work_s1;

endmodule

// File: src/rpc_queue.sv
// Short first-in first-out queue of work records between front and back.
// Depends on rpc_pkg.
module rpc_queue import rpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rpc_work_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output rpc_work_t head
);

	rpc_work_t               mem_q [QueueDepth];
	logic [QueuePtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [QueuePtrBits:0]   count_q;
	logic                    do_push, do_pop;

	assign full    = (count_q == (QueuePtrBits+1)'(QueueDepth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/rpc_back.sv
// Back part: an eight-stage restoring divider, one quotient bit per stage for
// all three channels, then the level mapping, the level-based classes and the
// output register. Depends on rpc_pkg.
module rpc_back import rpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      queue_empty,
	input  rpc_work_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output rpc_out_t  out_item
);

	rpc_work_t            stage_in [LevelBits];
	rpc_work_t            div_s [LevelBits];
	logic [LevelBits-1:0] vld_s;
	logic                 adv;
	logic                 out_valid_q;
	rpc_out_t             out_q;
	rpc_out_t             out_d;
	logic [LevelBits-1:0] lr, lg, lb, mx, mn;

	function automatic rpc_chan_t chan_step(input rpc_chan_t c, input logic [2:0] sh);
		rpc_chan_t          n;
		logic [RemBits-1:0] trial;
		n = c;
		trial = {{LevelBits{1'b0}}, c.div} << sh;
		if (c.rem >= trial) begin
			n.rem = c.rem - trial;
			n.quo[sh] = 1'b1;
		end
		return n;
	endfunction

	function automatic rpc_work_t work_step(input rpc_work_t w, input logic [2:0] sh);
		rpc_work_t n;
		n = w;
		n.red   = chan_step(w.red, sh);
		n.green = chan_step(w.green, sh);
		n.blue  = chan_step(w.blue, sh);
		return n;
	endfunction

	function automatic logic [LevelBits-1:0] level(input rpc_chan_t c);
		return c.empty ? '0 : LevelFull - c.quo;
	endfunction

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !queue_empty;

	assign stage_in[0] = head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LevelBits-2:0], pop};
		end
	end

	for (genvar k = 0; k < LevelBits; k++) begin : g_div
		if (k > 0) begin : g_link
			assign stage_in[k] = div_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[k] <= work_step(stage_in[k], 3'(LevelBits-1-k));
			end
		end
	end

	always_comb begin
		lr = level(div_s[LevelBits-1].red);
		lg = level(div_s[LevelBits-1].green);
		lb = level(div_s[LevelBits-1].blue);
		mx = lr;
		if (lg > mx) begin
			mx = lg;
		end
		if (lb > mx) begin
			mx = lb;
		end
		mn = lr;
		if (lg < mn) begin
			mn = lg;
		end
		if (lb < mn) begin
			mn = lb;
		end
		out_d.red_level   = lr;
		out_d.green_level = lg;
		out_d.blue_level  = lb;
		if (div_s[LevelBits-1].fixed) begin
			out_d.color_code = div_s[LevelBits-1].code;
		end else if (mx < BlackLimit) begin
			out_d.color_code = ColorBlack;
		end else if (mx > WhiteMaxLimit && mn > WhiteMinLimit && (mx - mn) < WhiteSpread) begin
			out_d.color_code = ColorWhite;
		end else begin
			out_d.color_code = div_s[LevelBits-1].code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[LevelBits-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[LevelBits-1]) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
